### rtl/isoep_pkg.sv
// Shared types, constants and tables for the date-time text to epoch converter.
package isoep_pkg;

  // Widths
  localparam int unsigned PosW   = 5;
  localparam int unsigned StepW  = 3;
  localparam int unsigned FieldW = 14;
  localparam int unsigned OperW  = 17;
  localparam int unsigned AccW   = 32;

  // Length of the fixed part of the text, YYYY-MM-DDThh:mm:ss
  localparam logic [PosW-1:0] FullLen = 5'd19;

  // Character codes
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChTee   = 8'h54;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;

  // Field range limits
  localparam logic [FieldW-1:0] YearMin = 14'd2000;
  localparam logic [FieldW-1:0] YearMax = 14'd2099;
  localparam logic [FieldW-1:0] MonMax  = 14'd12;
  localparam logic [FieldW-1:0] DayMax  = 14'd31;
  localparam logic [FieldW-1:0] HourMax = 14'd23;
  localparam logic [FieldW-1:0] MinMax  = 14'd59;

  // Scale constants for the multiply-add unit
  localparam logic [OperW-1:0] ScaleOne  = 17'd1;
  localparam logic [OperW-1:0] ScaleYear = 17'd365;
  localparam logic [OperW-1:0] ScaleDay  = 17'd86400;
  localparam logic [OperW-1:0] ScaleHour = 17'd3600;
  localparam logic [OperW-1:0] ScaleMin  = 17'd60;

  // Expected character class at a text position
  typedef enum logic [1:0] {
    CH_DIGIT,
    CH_DASH,
    CH_TSEP,
    CH_COLON
  } char_kind_e;

  // Field that ends at a text position
  typedef enum logic [2:0] {
    FC_NONE,
    FC_YEAR,
    FC_MONTH,
    FC_DAY,
    FC_HOUR,
    FC_MINUTE,
    FC_SECOND
  } field_close_e;

  // Operand source of the multiply-add unit
  typedef enum logic [2:0] {
    SRC_YEAR,
    SRC_LEAP,
    SRC_MONTH,
    SRC_DAY,
    SRC_ACC,
    SRC_HOUR,
    SRC_MINUTE,
    SRC_SECOND
  } calc_src_e;

  // Scale constant of the multiply-add unit
  typedef enum logic [2:0] {
    SC_ONE,
    SC_YEAR,
    SC_DAY,
    SC_HOUR,
    SC_MINUTE
  } calc_scale_e;

  // Sequencer states
  typedef enum logic {
    ST_PARSE,
    ST_CALC
  } seq_state_e;

  // Control word of the character program
  typedef struct packed {
    char_kind_e   kind;
    field_close_e close;
  } parse_word_t;

  // Control word of the epoch program
  typedef struct packed {
    calc_src_e   src;
    calc_scale_e scale;
    logic        accum;
    logic        last;
  } calc_word_t;

  // Parsed fields handed from the parser to the arithmetic unit
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } parsed_t;

  // Days before the first of a month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/isoep_ucode.sv
// Microcode ROMs: per-position character program and the epoch arithmetic program.
module isoep_ucode (
  input  logic [isoep_pkg::PosW-1:0]  pos_i,
  input  logic [isoep_pkg::StepW-1:0] step_i,
  output isoep_pkg::parse_word_t      pword_o,
  output isoep_pkg::calc_word_t       cword_o
);

  // Character program, one word per text position
  always_comb begin
    pword_o.kind  = isoep_pkg::CH_DIGIT;
    pword_o.close = isoep_pkg::FC_NONE;
    case (pos_i)
      5'd3:  pword_o.close = isoep_pkg::FC_YEAR;
      5'd4:  pword_o.kind  = isoep_pkg::CH_DASH;
      5'd6:  pword_o.close = isoep_pkg::FC_MONTH;
      5'd7:  pword_o.kind  = isoep_pkg::CH_DASH;
      5'd9:  pword_o.close = isoep_pkg::FC_DAY;
      5'd10: pword_o.kind  = isoep_pkg::CH_TSEP;
      5'd12: pword_o.close = isoep_pkg::FC_HOUR;
      5'd13: pword_o.kind  = isoep_pkg::CH_COLON;
      5'd15: pword_o.close = isoep_pkg::FC_MINUTE;
      5'd16: pword_o.kind  = isoep_pkg::CH_COLON;
      5'd18: pword_o.close = isoep_pkg::FC_SECOND;
      default: begin
        pword_o.kind  = isoep_pkg::CH_DIGIT;
        pword_o.close = isoep_pkg::FC_NONE;
      end
    endcase
  end

  // Epoch program: days, then scale to seconds, then add time of day
  always_comb begin
    cword_o.src   = isoep_pkg::SRC_YEAR;
    cword_o.scale = isoep_pkg::SC_ONE;
    cword_o.accum = 1'b1;
    cword_o.last  = 1'b0;
    case (step_i)
      3'd0: begin
        cword_o.src   = isoep_pkg::SRC_YEAR;
        cword_o.scale = isoep_pkg::SC_YEAR;
        cword_o.accum = 1'b0;
      end
      3'd1: cword_o.src = isoep_pkg::SRC_LEAP;
      3'd2: cword_o.src = isoep_pkg::SRC_MONTH;
      3'd3: cword_o.src = isoep_pkg::SRC_DAY;
      3'd4: begin
        cword_o.src   = isoep_pkg::SRC_ACC;
        cword_o.scale = isoep_pkg::SC_DAY;
        cword_o.accum = 1'b0;
      end
      3'd5: begin
        cword_o.src   = isoep_pkg::SRC_HOUR;
        cword_o.scale = isoep_pkg::SC_HOUR;
      end
      3'd6: begin
        cword_o.src   = isoep_pkg::SRC_MINUTE;
        cword_o.scale = isoep_pkg::SC_MINUTE;
      end
      3'd7: begin
        cword_o.src  = isoep_pkg::SRC_SECOND;
        cword_o.last = 1'b1;
      end
      default: begin
        cword_o.src  = isoep_pkg::SRC_SECOND;
        cword_o.last = 1'b1;
      end
    endcase
  end

endmodule

### rtl/isoep_parse.sv
// Character parser: position counter, decimal accumulator, field registers and error flag.
module isoep_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic                       clear_i,
  input  logic [7:0]                 char_i,
  input  isoep_pkg::parse_word_t     pword_i,
  output logic [isoep_pkg::PosW-1:0] pos_o,
  output isoep_pkg::parsed_t         fields_o,
  output logic                       ok_next_o
);

  logic [isoep_pkg::PosW-1:0]   pos_q, pos_d;
  logic [isoep_pkg::FieldW-1:0] fv_q, fv_d;
  logic [6:0]                   year_q, year_d;
  logic [3:0]                   month_q, month_d;
  logic [4:0]                   day_q, day_d;
  logic [4:0]                   hour_q, hour_d;
  logic [5:0]                   minute_q, minute_d;
  logic                         failed_q, failed_d;

  logic                         active;
  logic                         is_digit;
  logic                         bad;
  logic [17:0]                  fv_wide;
  logic [isoep_pkg::FieldW-1:0] fv_next;
  logic [isoep_pkg::FieldW-1:0] year_off;

  assign active   = take_i && !failed_q && (pos_q < isoep_pkg::FullLen);
  assign is_digit = (char_i >= isoep_pkg::ChZero) && (char_i <= isoep_pkg::ChNine);
  // Multiply by ten as two shifts and add the digit
  assign fv_wide  = {1'b0, fv_q, 3'b000} + {3'b000, fv_q, 1'b0} + {14'd0, char_i[3:0]};
  assign fv_next  = fv_wide[isoep_pkg::FieldW-1:0];
  assign year_off = fv_next - isoep_pkg::YearMin;

  // Check one character and advance the field registers
  always_comb begin
    pos_d    = pos_q;
    fv_d     = fv_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    bad      = 1'b0;
    if (active) begin
      case (pword_i.kind)
        isoep_pkg::CH_DIGIT: begin
          if (!is_digit) begin
            bad = 1'b1;
          end else begin
            fv_d = fv_next;
            case (pword_i.close)
              isoep_pkg::FC_YEAR: begin
                bad    = (fv_next < isoep_pkg::YearMin) || (fv_next > isoep_pkg::YearMax);
                year_d = year_off[6:0];
              end
              isoep_pkg::FC_MONTH: begin
                bad     = (fv_next == '0) || (fv_next > isoep_pkg::MonMax);
                month_d = fv_next[3:0];
              end
              isoep_pkg::FC_DAY: begin
                bad   = (fv_next == '0) || (fv_next > isoep_pkg::DayMax);
                day_d = fv_next[4:0];
              end
              isoep_pkg::FC_HOUR: begin
                bad    = fv_next > isoep_pkg::HourMax;
                hour_d = fv_next[4:0];
              end
              isoep_pkg::FC_MINUTE: begin
                bad      = fv_next > isoep_pkg::MinMax;
                minute_d = fv_next[5:0];
              end
              isoep_pkg::FC_SECOND: bad = fv_next > isoep_pkg::MinMax;
              default:              bad = 1'b0;
            endcase
          end
        end
        isoep_pkg::CH_DASH: begin
          bad  = char_i != isoep_pkg::ChDash;
          fv_d = '0;
        end
        isoep_pkg::CH_TSEP: begin
          bad  = (char_i != isoep_pkg::ChTee) && (char_i != isoep_pkg::ChSpace);
          fv_d = '0;
        end
        isoep_pkg::CH_COLON: begin
          bad  = char_i != isoep_pkg::ChColon;
          fv_d = '0;
        end
        default: bad = 1'b1;
      endcase
      if (!bad) begin
        pos_d = pos_q + 5'd1;
      end
    end
    failed_d = failed_q || bad;
  end

  assign ok_next_o = !failed_d && (pos_d == isoep_pkg::FullLen);

  // Hold parse state; drop it all at the end of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fv_q     <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      failed_q <= 1'b0;
    end else if (clear_i) begin
      pos_q    <= '0;
      fv_q     <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      failed_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      fv_q     <= fv_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      failed_q <= failed_d;
    end
  end

  assign pos_o           = pos_q;
  assign fields_o.year   = year_q;
  assign fields_o.month  = month_q;
  assign fields_o.day    = day_q;
  assign fields_o.hour   = hour_q;
  assign fields_o.minute = minute_q;
  assign fields_o.second = fv_q[5:0];

endmodule

### rtl/isoep_calc.sv
// Multiply-add datapath that runs the epoch program one control word per cycle while enabled.
module isoep_calc (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  isoep_pkg::calc_word_t      cword_i,
  input  isoep_pkg::parsed_t         fields_i,
  output logic [isoep_pkg::AccW-1:0] acc_next_o
);

  logic [isoep_pkg::AccW-1:0]    acc_q;
  logic [isoep_pkg::OperW-1:0]   operand;
  logic [isoep_pkg::OperW-1:0]   scale;
  logic [2*isoep_pkg::OperW-1:0] product;
  logic [7:0]                    leap_days;
  logic [8:0]                    month_days;
  logic                          leap_adj;

  // Leap days in earlier years and the day offset of the month
  assign leap_days  = ({1'b0, fields_i.year} + 8'd3) >> 2;
  assign leap_adj   = (fields_i.month > 4'd2) && (fields_i.year[1:0] == 2'b00);
  assign month_days = isoep_pkg::days_before(fields_i.month) + {8'd0, leap_adj};

  // Select the operand
  always_comb begin
    case (cword_i.src)
      isoep_pkg::SRC_YEAR:   operand = {10'd0, fields_i.year};
      isoep_pkg::SRC_LEAP:   operand = {9'd0, leap_days};
      isoep_pkg::SRC_MONTH:  operand = {8'd0, month_days};
      isoep_pkg::SRC_DAY:    operand = {12'd0, fields_i.day - 5'd1};
      isoep_pkg::SRC_ACC:    operand = acc_q[isoep_pkg::OperW-1:0];
      isoep_pkg::SRC_HOUR:   operand = {12'd0, fields_i.hour};
      isoep_pkg::SRC_MINUTE: operand = {11'd0, fields_i.minute};
      isoep_pkg::SRC_SECOND: operand = {11'd0, fields_i.second};
      default:               operand = '0;
    endcase
  end

  // Select the scale constant
  always_comb begin
    case (cword_i.scale)
      isoep_pkg::SC_ONE:    scale = isoep_pkg::ScaleOne;
      isoep_pkg::SC_YEAR:   scale = isoep_pkg::ScaleYear;
      isoep_pkg::SC_DAY:    scale = isoep_pkg::ScaleDay;
      isoep_pkg::SC_HOUR:   scale = isoep_pkg::ScaleHour;
      isoep_pkg::SC_MINUTE: scale = isoep_pkg::ScaleMin;
      default:              scale = isoep_pkg::ScaleOne;
    endcase
  end

  // Multiply, then add to the accumulator or start it afresh
  assign product    = operand * scale;
  assign acc_next_o = (cword_i.accum ? acc_q : '0) + product[isoep_pkg::AccW-1:0];

  // Advance the accumulator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_next_o;
    end
  end

endmodule

### rtl/iso8601_text_to_epoch_top.sv
// Top level: date-time text to seconds since 2000-01-01, with its microcode sequencer.
//
// Input stream: one ASCII character per transfer on s_axis_tdata, s_axis_tlast on the
// final character of a string. The text is YYYY-MM-DD, T or space, hh:mm:ss; anything
// after the seconds is ignored.
// Output stream: one transfer per string, on its last character. m_axis_tuser is 1 when
// the text parsed and all fields were in range; m_axis_tdata then holds the seconds
// since 2000-01-01 00:00:00, and is zero otherwise.
// Throughput: one character per cycle while a string is read and the output register
// is free. A failed or short string loads its result into the output register with
// its last character. A good string runs the eight-word epoch program through the
// single multiply-add unit; the input stalls while it runs, and its last word loads
// the result into the output register.
// The result sits in an output register. Characters of the next string are taken while
// the register is empty or being transferred; when the receiver holds tready low with
// the register full, the input stalls and a finished epoch program holds its last word.
// Reset clears the parser and drops any pending result; the next character starts a
// new string.
module iso8601_text_to_epoch_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] epoch_seconds
  output logic        m_axis_tuser    // [0] ok
);

  isoep_pkg::seq_state_e          state_q, state_d;
  logic [isoep_pkg::StepW-1:0]    step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_ok_q;
  logic [isoep_pkg::AccW-1:0]     out_epoch_q;

  logic [isoep_pkg::PosW-1:0]     pos;
  isoep_pkg::parse_word_t         pword;
  isoep_pkg::calc_word_t          cword;
  isoep_pkg::parsed_t             fields;
  logic                           ok_next;
  logic [isoep_pkg::AccW-1:0]     acc_next;
  logic                           accept_in;
  logic                           out_free;
  logic                           calc_en;
  logic                           clear;
  logic                           load;
  logic                           load_ok;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == isoep_pkg::ST_PARSE) && out_free;
  assign accept_in     = s_axis_tvalid && s_axis_tready;

  isoep_ucode u_ucode (
    .pos_i   (pos),
    .step_i  (step_q),
    .pword_o (pword),
    .cword_o (cword)
  );

  isoep_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (accept_in),
    .clear_i   (clear),
    .char_i    (s_axis_tdata),
    .pword_i   (pword),
    .pos_o     (pos),
    .fields_o  (fields),
    .ok_next_o (ok_next)
  );

  isoep_calc u_calc (
    .clk_i      (clk_i),
    .en_i       (calc_en),
    .cword_i    (cword),
    .fields_i   (fields),
    .acc_next_o (acc_next)
  );

  // Sequencer: branch on the parse result, then step through the epoch program
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    calc_en = 1'b0;
    clear   = 1'b0;
    load    = 1'b0;
    load_ok = 1'b0;
    case (state_q)
      isoep_pkg::ST_PARSE: begin
        if (accept_in && s_axis_tlast) begin
          if (ok_next) begin
            state_d = isoep_pkg::ST_CALC;
            step_d  = '0;
          end else begin
            load  = 1'b1;
            clear = 1'b1;
          end
        end
      end
      isoep_pkg::ST_CALC: begin
        if (cword.last) begin
          if (out_free) begin
            calc_en = 1'b1;
            load    = 1'b1;
            load_ok = 1'b1;
            clear   = 1'b1;
            state_d = isoep_pkg::ST_PARSE;
            step_d  = '0;
          end
        end else begin
          calc_en = 1'b1;
          step_d  = step_q + 3'd1;
        end
      end
      default: begin
        state_d = isoep_pkg::ST_PARSE;
        step_d  = '0;
      end
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isoep_pkg::ST_PARSE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Output register: load a result, drop it once transferred
  assign out_valid_d = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_ok_q    <= load_ok;
      out_epoch_q <= load_ok ? acc_next : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_epoch_q;
  assign m_axis_tuser  = out_ok_q;

`ifndef ASSERT_OFF
  // No character is taken while the epoch program runs
  a_no_input_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == isoep_pkg::ST_CALC) |-> !s_axis_tready)
    else $error("character taken during epoch calculation");

  // The program always starts at its first word
  a_step_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == isoep_pkg::ST_PARSE) |-> (step_q == '0))
    else $error("step counter not at zero while parsing");

  // A last character either starts the program or yields a result
  a_last_leads_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_in && s_axis_tlast) |=> ((state_q == isoep_pkg::ST_CALC) || m_axis_tvalid))
    else $error("last character produced neither calculation nor result");

  // A failed string reports zero seconds
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("nonzero epoch on failed string");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result loaded over an untransferred one");
`endif

endmodule
